@@ src/mi3_pkg.sv @@
// Shared types, widths, cofactor index tables and result formatting for the 3x3 inverse.
package mi3_pkg;

  // Element width and the widths that follow from it
  localparam int EB = 16;
  localparam int PW = 2 * EB;        // one cofactor product
  localparam int AW = PW + 1;        // adjugate term
  localparam int TW = EB + AW;       // element times adjugate term
  localparam int DW = 3 * EB + 3;    // determinant
  localparam int QB = 2 * EB;        // adjugate magnitude and quotient
  localparam int RW = 32;            // result element
  localparam int XW = (QB + 1 > RW) ? QB + 1 : RW;

  // adj[k] = m[PA[k]] * m[PB[k]] - m[NA[k]] * m[NB[k]]
  localparam int unsigned PA [9] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
  localparam int unsigned PB [9] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
  localparam int unsigned NA [9] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
  localparam int unsigned NB [9] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

  typedef logic [8:0][EB-1:0] mat_t;
  typedef logic [8:0][AW-1:0] adj_t;
  typedef logic [8:0][QB-1:0] mag_t;

  typedef struct packed {
    logic signed [EB-1:0] m00;
    logic signed [EB-1:0] m01;
    logic signed [EB-1:0] m02;
    logic signed [EB-1:0] m10;
    logic signed [EB-1:0] m11;
    logic signed [EB-1:0] m12;
    logic signed [EB-1:0] m20;
    logic signed [EB-1:0] m21;
    logic signed [EB-1:0] m22;
  } in_item_t;

  typedef struct packed {
    logic signed [RW-1:0] r00;
    logic signed [RW-1:0] r01;
    logic signed [RW-1:0] r02;
    logic signed [RW-1:0] r10;
    logic signed [RW-1:0] r11;
    logic signed [RW-1:0] r12;
    logic signed [RW-1:0] r20;
    logic signed [RW-1:0] r21;
    logic signed [RW-1:0] r22;
    logic                 invertible;
  } out_item_t;

  // Data carried alongside the divider lanes
  typedef struct packed {
    mat_t       m;
    logic       nz;
    logic [8:0] qneg;
  } side_t;

  // One divider stage: partial remainders, numerators still to shift, quotients
  typedef struct packed {
    mag_t          rem;
    mag_t          num;
    mag_t          quo;
    logic [DW-1:0] d;
    side_t         side;
  } dstg_t;

  // Signed quotient to result width (wraps above RW bits)
  function automatic logic [RW-1:0] qfmt(logic [QB-1:0] q, logic neg);
    logic signed [QB:0]   qs;
    logic signed [XW-1:0] wide;
    qs   = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
    wide = XW'(qs);
    return wide[RW-1:0];
  endfunction

  // Pass-through element to result width
  function automatic logic [RW-1:0] mfmt(logic [EB-1:0] e);
    logic signed [XW-1:0] wide;
    wide = XW'($signed(e));
    return wide[RW-1:0];
  endfunction

endpackage

@@ src/mi3_cofactor.sv @@
// Two-stage cofactor unit: eighteen products, then nine adjugate differences.
module mi3_cofactor import mi3_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic in_valid,
  input  mat_t in_mat,
  output logic out_valid,
  output adj_t out_adj,
  output mat_t out_mat
);

  logic signed [PW-1:0] pp_r [9];
  logic signed [PW-1:0] pn_r [9];
  mat_t m_a_r;
  mat_t m_b_r;
  adj_t adj_r;
  logic v_a_r;
  logic v_b_r;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_a_r <= 1'b0;
      v_b_r <= 1'b0;
    end else if (en) begin
      v_a_r <= in_valid;
      v_b_r <= v_a_r;
    end
  end

  // stage A: products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 9; k++) begin
        pp_r[k] <= $signed(in_mat[PA[k]]) * $signed(in_mat[PB[k]]);
        pn_r[k] <= $signed(in_mat[NA[k]]) * $signed(in_mat[NB[k]]);
      end
      m_a_r <= in_mat;
    end
  end

  // stage B: differences
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 9; k++) begin
        adj_r[k] <= AW'(pp_r[k]) - AW'(pn_r[k]);
      end
      m_b_r <= m_a_r;
    end
  end

  assign out_valid = v_b_r;
  assign out_adj   = adj_r;
  assign out_mat   = m_b_r;

endmodule

@@ src/mi3_det.sv @@
// Three-stage determinant unit: first-row products, sum, then magnitudes and signs.
module mi3_det import mi3_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  adj_t          in_adj,
  input  mat_t          in_mat,
  output logic          out_valid,
  output logic [DW-1:0] out_dmag,
  output mag_t          out_amag,
  output side_t         out_side
);

  logic signed [TW-1:0] dp_r [3];
  adj_t                 adj_c_r;
  mat_t                 m_c_r;
  logic signed [DW-1:0] det_r;
  mag_t                 amag_d_r;
  logic [8:0]           aneg_d_r;
  mat_t                 m_d_r;
  logic [DW-1:0]        dmag_r;
  mag_t                 amag_e_r;
  side_t                side_r;
  logic [2:0]           v_r;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[1:0], in_valid};
    end
  end

  // stage C: element times cofactor along the first row
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        dp_r[k] <= $signed(in_mat[k]) * $signed(in_adj[3 * k]);
      end
      adj_c_r <= in_adj;
      m_c_r   <= in_mat;
    end
  end

  // stage D: determinant sum, adjugate magnitudes
  always_ff @(posedge clk) begin
    logic signed [AW-1:0] a;
    logic signed [AW-1:0] na;
    if (en) begin
      det_r <= DW'(dp_r[0]) + DW'(dp_r[1]) + DW'(dp_r[2]);
      for (int k = 0; k < 9; k++) begin
        a  = $signed(adj_c_r[k]);
        na = -a;
        aneg_d_r[k] <= a[AW-1];
        amag_d_r[k] <= a[AW-1] ? na[QB-1:0] : a[QB-1:0];
      end
      m_d_r <= m_c_r;
    end
  end

  // stage E: determinant magnitude, result signs, nonzero flag
  always_ff @(posedge clk) begin
    logic signed [DW-1:0] nd;
    if (en) begin
      nd = -det_r;
      dmag_r      <= det_r[DW-1] ? nd : det_r;
      amag_e_r    <= amag_d_r;
      side_r.m    <= m_d_r;
      side_r.nz   <= |det_r;
      side_r.qneg <= aneg_d_r ^ {9{det_r[DW-1]}};
    end
  end

  assign out_valid = v_r[2];
  assign out_dmag  = dmag_r;
  assign out_amag  = amag_e_r;
  assign out_side  = side_r;

endmodule

@@ src/mi3_div_pipe.sv @@
// Nine-lane restoring divider, one quotient bit per register stage.
module mi3_div_pipe import mi3_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [DW-1:0] in_dmag,
  input  mag_t          in_amag,
  input  side_t         in_side,
  output logic          out_valid,
  output mag_t          out_quo,
  output side_t         out_side
);

  dstg_t      st_in [QB];
  dstg_t      st_r  [QB];
  logic [QB-1:0] v_r;

  // stage 0 takes the dividend fresh
  assign st_in[0] = '{rem: '0, num: in_amag, quo: '0, d: in_dmag, side: in_side};

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[QB-2:0], in_valid};
    end
  end

  for (genvar s = 0; s < QB; s++) begin : g_stage
    dstg_t nxt;

    if (s > 0) begin : g_link
      assign st_in[s] = st_r[s-1];
    end

    // shift in the next numerator bit, trial subtract
    always_comb begin
      logic [DW-1:0] trial;
      logic [DW-1:0] diff;
      logic          ge;
      nxt = st_in[s];
      for (int k = 0; k < 9; k++) begin
        trial = DW'({st_in[s].rem[k], st_in[s].num[k][QB-1]});
        diff  = trial - st_in[s].d;
        ge    = trial >= st_in[s].d;
        nxt.rem[k] = ge ? diff[QB-1:0] : trial[QB-1:0];
        nxt.num[k] = {st_in[s].num[k][QB-2:0], 1'b0};
        nxt.quo[k] = {st_in[s].quo[k][QB-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_r[s] <= nxt;
      end
    end
  end

  assign out_valid = v_r[QB-1];
  assign out_quo   = st_r[QB-1].quo;
  assign out_side  = st_r[QB-1].side;

  // the finished remainder of lane 0 is always below a nonzero divisor
  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[QB-1] && st_r[QB-1].side.nz |-> DW'(st_r[QB-1].rem[0]) < st_r[QB-1].d)
    else $error("remainder not below divisor");

endmodule

@@ src/matrix3_integer_inverse.sv @@
// Stages from input transfer to result: 2 cofactor, 3 determinant, 32 divider and
// 1 output register. Throughput: one matrix per cycle while no result is held;
// the divider's 32 one-bit stages set the depth.
// A stalled result holds every stage, bubbles included, and stalls the input.
// Reset (synchronous, active low) clears all valid bits; data registers are not reset.
module matrix3_integer_inverse import mi3_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  mat_t          in_mat;
  logic          en;
  logic          cf_valid;
  adj_t          cf_adj;
  mat_t          cf_mat;
  logic          dt_valid;
  logic [DW-1:0] dt_dmag;
  mag_t          dt_amag;
  side_t         dt_side;
  logic          dv_valid;
  mag_t          dv_quo;
  side_t         dv_side;
  logic          out_valid_r;
  out_item_t     out_data_r;
  out_item_t     res;
  logic [8:0][RW-1:0] rv;

  // pipeline moves unless a result is held
  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  assign in_mat = {in_data.m22, in_data.m21, in_data.m20,
                   in_data.m12, in_data.m11, in_data.m10,
                   in_data.m02, in_data.m01, in_data.m00};

  mi3_cofactor u_cofactor (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(in_valid), .in_mat(in_mat),
    .out_valid(cf_valid), .out_adj(cf_adj), .out_mat(cf_mat)
  );

  mi3_det u_det (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(cf_valid), .in_adj(cf_adj), .in_mat(cf_mat),
    .out_valid(dt_valid), .out_dmag(dt_dmag), .out_amag(dt_amag), .out_side(dt_side)
  );

  mi3_div_pipe u_div (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(dt_valid), .in_dmag(dt_dmag), .in_amag(dt_amag), .in_side(dt_side),
    .out_valid(dv_valid), .out_quo(dv_quo), .out_side(dv_side)
  );

  // signed quotient or pass-through
  always_comb begin
    for (int k = 0; k < 9; k++) begin
      rv[k] = dv_side.nz ? qfmt(dv_quo[k], dv_side.qneg[k]) : mfmt(dv_side.m[k]);
    end
    res.r00 = rv[0];
    res.r01 = rv[1];
    res.r02 = rv[2];
    res.r10 = rv[3];
    res.r11 = rv[4];
    res.r12 = rv[5];
    res.r20 = rv[6];
    res.r21 = rv[7];
    res.r22 = rv[8];
    res.invertible = dv_side.nz;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_no_result_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

  a_held_result_stays: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("held result lost or changed");

  a_taken_result_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall |-> !in_stall)
    else $error("input stalled while result taken");

endmodule

@@ tb/sv/tb_matrix3_integer_inverse.sv @@
// Self-checking testbench for the pipelined 3x3 integer matrix inverse.
module tb_matrix3_integer_inverse;
  import mi3_pkg::*;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  logic      in_stall_q;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  in_item_t  pending_mats[$];
  out_item_t expected_inverses[$];
  int        fail_count;
  bit        calm_phase;
  int        hold_off_cycles;
  int        hold_off_starts;

  matrix3_integer_inverse dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // Clock
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Truncating signed division of an adjugate term by the determinant
  function automatic logic [31:0] adj_over_det(longint adj, logic signed [127:0] det);
    logic signed [127:0] q;
    q = $signed(128'(adj)) / det;
    return q[31:0];
  endfunction

  // Expected inverse of one matrix
  function automatic out_item_t inverse_of(in_item_t a);
    longint m[9];
    longint adj[9];
    logic signed [127:0] det;
    logic [31:0] r[9];
    out_item_t o;
    m[0] = a.m00; m[1] = a.m01; m[2] = a.m02;
    m[3] = a.m10; m[4] = a.m11; m[5] = a.m12;
    m[6] = a.m20; m[7] = a.m21; m[8] = a.m22;
    adj[0] = m[4] * m[8] - m[5] * m[7];
    adj[1] = m[2] * m[7] - m[1] * m[8];
    adj[2] = m[1] * m[5] - m[2] * m[4];
    adj[3] = m[5] * m[6] - m[3] * m[8];
    adj[4] = m[0] * m[8] - m[2] * m[6];
    adj[5] = m[2] * m[3] - m[0] * m[5];
    adj[6] = m[3] * m[7] - m[4] * m[6];
    adj[7] = m[1] * m[6] - m[0] * m[7];
    adj[8] = m[0] * m[4] - m[1] * m[3];
    det = $signed(128'(m[0])) * $signed(128'(adj[0]))
        + $signed(128'(m[1])) * $signed(128'(adj[3]))
        + $signed(128'(m[2])) * $signed(128'(adj[6]));
    for (int i = 0; i < 9; i++)
      r[i] = (det != 0) ? adj_over_det(adj[i], det) : 32'(m[i]);
    o.r00 = r[0]; o.r01 = r[1]; o.r02 = r[2];
    o.r10 = r[3]; o.r11 = r[4]; o.r12 = r[5];
    o.r20 = r[6]; o.r21 = r[7]; o.r22 = r[8];
    o.invertible = (det != 0);
    return o;
  endfunction

  function automatic in_item_t mat_of(logic [15:0] e[9]);
    in_item_t a;
    a.m00 = e[0]; a.m01 = e[1]; a.m02 = e[2];
    a.m10 = e[3]; a.m11 = e[4]; a.m12 = e[5];
    a.m20 = e[6]; a.m21 = e[7]; a.m22 = e[8];
    return a;
  endfunction

  // Random element: mostly small values so that quotients are often nonzero
  function automatic logic [15:0] rand_elem();
    int k;
    k = $urandom_range(0, 9);
    if (k < 5) return 16'($signed($urandom_range(0, 8)) - 4);
    if (k < 7) return 16'($signed($urandom_range(0, 200)) - 100);
    if (k < 8) return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
    return 16'($urandom);
  endfunction

  // Stimulus
  initial begin
    logic [15:0] e[9];
    // identity, scaled identity, extremes, singular cases, unimodular
    for (int i = 0; i < 9; i++) e[i] = (i % 4 == 0) ? 16'd1 : 16'd0;
    pending_mats.push_back(mat_of(e));
    for (int i = 0; i < 9; i++) e[i] = (i % 4 == 0) ? 16'hffff : 16'd0;
    pending_mats.push_back(mat_of(e));
    for (int i = 0; i < 9; i++) e[i] = (i % 4 == 0) ? 16'd2 : 16'd0;
    pending_mats.push_back(mat_of(e));
    for (int i = 0; i < 9; i++) e[i] = 16'h0000;
    pending_mats.push_back(mat_of(e));
    for (int i = 0; i < 9; i++) e[i] = 16'h7fff;
    pending_mats.push_back(mat_of(e));
    for (int i = 0; i < 9; i++) e[i] = 16'h8000;
    pending_mats.push_back(mat_of(e));
    for (int i = 0; i < 9; i++) e[i] = 16'hffff;
    pending_mats.push_back(mat_of(e));
    for (int i = 0; i < 9; i++) e[i] = (i % 4 == 0) ? 16'h8000 : 16'h7fff;
    pending_mats.push_back(mat_of(e));
    for (int i = 0; i < 9; i++) e[i] = (i % 4 == 0) ? 16'h7fff : 16'h8000;
    pending_mats.push_back(mat_of(e));
    for (int i = 0; i < 9; i++) e[i] = (i % 4 == 0) ? 16'h8000 : 16'h0000;
    pending_mats.push_back(mat_of(e));
    for (int i = 0; i < 9; i++) e[i] = (i % 2) ? 16'h8000 : 16'h7fff;
    pending_mats.push_back(mat_of(e));
    for (int i = 0; i < 9; i++) e[i] = (i % 2) ? 16'h5555 : 16'haaaa;
    pending_mats.push_back(mat_of(e));
    // upper triangular with unit diagonal, determinant one
    e = '{16'd1, 16'd5, 16'hfffd, 16'd0, 16'd1, 16'd7, 16'd0, 16'd0, 16'd1};
    pending_mats.push_back(mat_of(e));
    // determinant of -1 and a large determinant giving zero quotients
    e = '{16'd0, 16'd1, 16'd0, 16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1};
    pending_mats.push_back(mat_of(e));
    e = '{16'd1000, 16'd0, 16'd0, 16'd0, 16'd1000, 16'd0, 16'd0, 16'd0, 16'd1000};
    pending_mats.push_back(mat_of(e));
    // two equal rows, singular
    e = '{16'd3, 16'd4, 16'd5, 16'd3, 16'd4, 16'd5, 16'd1, 16'd2, 16'd9};
    pending_mats.push_back(mat_of(e));
    // random part: a third forced singular by copying one row onto another
    for (int n = 0; n < 640; n++) begin
      for (int i = 0; i < 9; i++) e[i] = rand_elem();
      if ($urandom_range(0, 2) == 0) begin
        for (int c = 0; c < 3; c++) e[3 + c] = e[c];
      end
      pending_mats.push_back(mat_of(e));
    end
  end

  // Reset and end of run
  initial begin
    int settle;
    fail_count = 0;
    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    wait (pending_mats.size() == 0 && !in_valid);
    wait (expected_inverses.size() == 0);
    for (settle = 0; settle < 60; settle++) @(posedge clk);
    if (fail_count == 0)
      $display("matrix3_integer_inverse test passed");
    else
      $display("matrix3_integer_inverse test failed");
    $finish;
  end

  // Time limit
  initial begin
    #2000000;
    $display("matrix3_integer_inverse test failed");
    $finish;
  end

  // Calm stretch: a window with no random idling on either side and no new hold-off
  initial begin
    calm_phase = 1'b0;
    repeat (300) @(posedge clk);
    calm_phase = 1'b1;
    repeat (200) @(posedge clk);
    calm_phase = 1'b0;
  end

  // Driver: changes on the falling edge, holds a stalled transfer
  initial begin
    in_valid = 1'b0;
    in_data = '0;
  end
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || !in_stall_q) begin
        if (pending_mats.size() > 0 && (calm_phase || $urandom_range(0, 99) >= 33)) begin
          in_data  <= pending_mats.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Stall sampled at the last rising edge decides whether the offer was taken
  initial in_stall_q = 1'b0;
  always @(posedge clk) begin
    in_stall_q <= in_stall;
    if (rst_n && in_valid && !in_stall)
      expected_inverses.push_back(inverse_of(in_data));
  end

  // Receiver stall: random, with a long hold-off early on so the pipeline fills, and at most one more later
  initial begin
    out_stall = 1'b0;
    hold_off_cycles = 0;
    hold_off_starts = 0;
  end
  always @(negedge clk) begin
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_stall <= 1'b1;
    end else if (!calm_phase && expected_inverses.size() > 10
                 && (hold_off_starts == 0
                     || (hold_off_starts < 2 && $urandom_range(0, 199) == 0))) begin
      hold_off_starts <= hold_off_starts + 1;
      hold_off_cycles <= 150;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm_phase && ($urandom_range(0, 99) < 33);
    end
  end

  // Monitor: compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_inverses.size() == 0) begin
        $error("unexpected result transfer: %p", out_data);
        fail_count++;
      end else begin
        want = expected_inverses.pop_front();
        if (out_data.r00 !== want.r00) begin
          $error("r00 expected %0d actual %0d", want.r00, out_data.r00); fail_count++;
        end
        if (out_data.r01 !== want.r01) begin
          $error("r01 expected %0d actual %0d", want.r01, out_data.r01); fail_count++;
        end
        if (out_data.r02 !== want.r02) begin
          $error("r02 expected %0d actual %0d", want.r02, out_data.r02); fail_count++;
        end
        if (out_data.r10 !== want.r10) begin
          $error("r10 expected %0d actual %0d", want.r10, out_data.r10); fail_count++;
        end
        if (out_data.r11 !== want.r11) begin
          $error("r11 expected %0d actual %0d", want.r11, out_data.r11); fail_count++;
        end
        if (out_data.r12 !== want.r12) begin
          $error("r12 expected %0d actual %0d", want.r12, out_data.r12); fail_count++;
        end
        if (out_data.r20 !== want.r20) begin
          $error("r20 expected %0d actual %0d", want.r20, out_data.r20); fail_count++;
        end
        if (out_data.r21 !== want.r21) begin
          $error("r21 expected %0d actual %0d", want.r21, out_data.r21); fail_count++;
        end
        if (out_data.r22 !== want.r22) begin
          $error("r22 expected %0d actual %0d", want.r22, out_data.r22); fail_count++;
        end
        if (out_data.invertible !== want.invertible) begin
          $error("invertible expected %0b actual %0b", want.invertible, out_data.invertible);
          fail_count++;
        end
      end
    end
  end

endmodule
